// ===== rtl/pso_pkg.sv =====
package pso_pkg;

  // Default swarm geometry and the stored value width.
  localparam int POP_DEF = 32;
  localparam int DIM_DEF = 8;
  localparam int VALUE_BITS = 32;

  // Field widths fixed by the port list.
  localparam int CMD_W = 3;
  localparam int MEMBER_W = 5;
  localparam int COORD_W = 3;
  localparam int WORD_W = 32;
  localparam int GAIN_W = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;
  localparam int NMEM_W = 6;
  localparam int NDIM_W = 4;

  // Register reset values.
  localparam logic [GAIN_W-1:0] INERTIA_RST = 16'd2986;
  localparam logic [GAIN_W-1:0] OWN_GAIN_RST = 16'd6121;
  localparam logic [GAIN_W-1:0] SWARM_GAIN_RST = 16'd6121;
  localparam logic [NMEM_W-1:0] MEMBERS_RST = 6'd32;
  localparam logic [NDIM_W-1:0] DIMS_RST = 4'd8;

  // Global best cost before any report.
  localparam logic [WORD_W-1:0] COST_MAX = 32'h7FFF_FFFF;

  typedef enum logic [CMD_W-1:0] {
    CMD_RESTART = 3'd0,
    CMD_LOAD    = 3'd1,
    CMD_READ    = 3'd2,
    CMD_REPORT  = 3'd3,
    CMD_EVOLVE  = 3'd4,
    CMD_BEST    = 3'd5
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INERTIA    = 3'd0,
    REG_OWN_GAIN   = 3'd1,
    REG_SWARM_GAIN = 3'd2,
    REG_MEMBERS    = 3'd3,
    REG_DIMS       = 3'd4
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_RPT,
    ST_COPY_RD,
    ST_COPY_WR,
    ST_EVO,
    ST_VCLR
  } state_t;

  // Operand pair selected for the shared multiplier.
  typedef enum logic [1:0] {
    SEL_INERTIA,
    SEL_OWN,
    SEL_SWARM
  } mac_sel_t;

  typedef struct packed {
    logic     mul_en;
    mac_sel_t sel;
    logic     acc_clr;
    logic     acc_add;
  } mac_ctl_t;

endpackage

// ===== rtl/pso_ram.sv =====
module pso_ram #(
  parameter int AW = 8,
  parameter int W = pso_pkg::VALUE_BITS
) (
  input  logic         clk,
  input  logic         we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic         re,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [2**AW];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/pso_mac.sv =====
module pso_mac (
  input  logic                                clk,
  input  pso_pkg::mac_ctl_t                   ctl,
  input  logic [pso_pkg::GAIN_W-1:0]          w,
  input  logic [pso_pkg::GAIN_W-1:0]          c1,
  input  logic [pso_pkg::GAIN_W-1:0]          c2,
  input  logic signed [pso_pkg::VALUE_BITS-1:0] x,
  input  logic signed [pso_pkg::VALUE_BITS-1:0] v,
  input  logic signed [pso_pkg::VALUE_BITS-1:0] pb,
  input  logic signed [pso_pkg::VALUE_BITS-1:0] gb,
  output logic signed [pso_pkg::VALUE_BITS-1:0] v_new,
  output logic signed [pso_pkg::VALUE_BITS-1:0] x_new
);

  localparam int VB = pso_pkg::VALUE_BITS;
  localparam int GW = pso_pkg::GAIN_W;
  localparam int PW = GW + 1 + VB + 1;
  localparam int AC = PW + 2;
  localparam int SH = 13;
  localparam int QW = AC - SH;

  logic [GW-1:0]         op_a;
  logic signed [VB:0]    op_b;
  logic signed [PW-1:0]  prod;
  logic signed [AC-1:0]  acc;
  logic signed [QW-1:0]  quo;
  logic signed [VB:0]    xsum;

  // Operand select: the inertia term uses twice the velocity.
  always_comb begin
    unique case (ctl.sel)
      pso_pkg::SEL_INERTIA: begin
        op_a = w;
        op_b = {v, 1'b0};
      end
      pso_pkg::SEL_OWN: begin
        op_a = c1;
        op_b = (VB + 1)'(pb) - (VB + 1)'(x);
      end
      default: begin
        op_a = c2;
        op_b = (VB + 1)'(gb) - (VB + 1)'(x);
      end
    endcase
  end

  // Shared multiplier, registered, then accumulated.
  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod <= $signed({1'b0, op_a}) * op_b;
    end
    if (ctl.acc_clr) begin
      acc <= '0;
    end else if (ctl.acc_add) begin
      acc <= acc + AC'(prod);
    end
  end

  // Floor divide by 8192 and saturate velocity and position.
  always_comb begin
    quo = QW'(acc >>> SH);
    if (quo[QW-1:VB-1] == '0 || quo[QW-1:VB-1] == '1) begin
      v_new = quo[VB-1:0];
    end else if (quo[QW-1]) begin
      v_new = {1'b1, {(VB-1){1'b0}}};
    end else begin
      v_new = {1'b0, {(VB-1){1'b1}}};
    end
    xsum = (VB + 1)'(x) + (VB + 1)'(v_new);
    if (xsum[VB] == xsum[VB-1]) begin
      x_new = xsum[VB-1:0];
    end else if (xsum[VB]) begin
      x_new = {1'b1, {(VB-1){1'b0}}};
    end else begin
      x_new = {1'b0, {(VB-1){1'b1}}};
    end
  end

endmodule

// ===== rtl/particle_swarm_update_engine.sv =====
// Load, read best, unused codes and an out-of-range read or report raise done in the cycle
// after start is taken. Read position goes via ST_READ, a report via ST_RPT; an improving
// one then copies the row. Evolve forms three products per word on one shared multiplier.
// Restart clears the velocity memory, POP*DIM words at one a cycle, then reports.
// One command at a time; busy is high until done. The receiver cannot stall a result.
// Reset (rst, synchronous) clears marks and control, sets best cost to most positive.
module particle_swarm_update_engine #(
  parameter int POP = pso_pkg::POP_DEF,
  parameter int DIM = pso_pkg::DIM_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  output logic                                  busy,
  input  logic [pso_pkg::CMD_W-1:0]             command,
  input  logic [pso_pkg::MEMBER_W-1:0]          member,
  input  logic [pso_pkg::COORD_W-1:0]           coord,
  input  logic signed [pso_pkg::WORD_W-1:0]     load_value,
  input  logic signed [pso_pkg::WORD_W-1:0]     cost,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [pso_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [pso_pkg::CFG_DATA_W-1:0]        cfg_data,
  output logic                                  done,
  output logic signed [pso_pkg::WORD_W-1:0]     read_value,
  output logic signed [pso_pkg::WORD_W-1:0]     best_cost,
  output logic                                  best_valid,
  output logic                                  particle_improved,
  output logic                                  global_improved
);

  localparam int VB = pso_pkg::VALUE_BITS;
  localparam int MW = (POP > 1) ? $clog2(POP) : 1;
  localparam int DW = (DIM > 1) ? $clog2(DIM) : 1;
  localparam int AW = MW + DW;
  localparam int NW = $clog2(POP + 1) + 1;
  localparam int DNW = $clog2(DIM + 1) + 1;

  pso_pkg::state_t state, state_next;
  pso_pkg::mac_ctl_t mac_ctl;

  logic [pso_pkg::GAIN_W-1:0] inertia_weight, own_best_gain, swarm_best_gain;
  logic [pso_pkg::NMEM_W-1:0] members_in_use;
  logic [pso_pkg::NDIM_W-1:0] dims_in_use;

  logic [MW-1:0] mi;
  logic [DW-1:0] dj;
  logic [2:0]    ph;
  logic [pso_pkg::WORD_W-1:0] cost_r;
  logic [POP-1:0] own_marks;
  logic           swarm_mark;
  logic [pso_pkg::WORD_W-1:0] swarm_cost;
  logic [VB-1:0]  swarm_pos [DIM];
  logic           pimp, gimp;
  logic [pso_pkg::WORD_W-1:0] rv;

  logic [NW-1:0]  nm;
  logic [DNW-1:0] nd;
  logic           m_ok, c_ok, acc_in, last_i, last_j, own_imp, sweep_end;
  logic [AW-1:0]  addr_port, addr_cur, addr;
  logic [VB-1:0]  pos_q, vel_q, pb_q, gb;
  logic [pso_pkg::WORD_W-1:0] cost_q;
  logic signed [VB-1:0] v_new, x_new;
  logic           rd_en, pos_we, vel_we, pb_we, cost_we;
  logic [VB-1:0]  pos_wd, vel_wd, pb_wd;
  logic [MW-1:0]  cost_addr;

  assign cfg_ready = 1'b1;
  assign busy = (state != pso_pkg::ST_IDLE);
  assign acc_in = start && !busy;
  assign read_value = rv;
  assign best_cost = swarm_cost;
  assign best_valid = swarm_mark;
  assign particle_improved = pimp;
  assign global_improved = gimp;

  // Active counts, clamped to the built size.
  always_comb begin
    if (members_in_use == '0) begin
      nm = NW'(1);
    end else if (32'(members_in_use) > 32'(POP)) begin
      nm = NW'(POP);
    end else begin
      nm = NW'(members_in_use);
    end
    if (dims_in_use == '0) begin
      nd = DNW'(1);
    end else if (32'(dims_in_use) > 32'(DIM)) begin
      nd = DNW'(DIM);
    end else begin
      nd = DNW'(dims_in_use);
    end
  end

  assign m_ok = 32'(member) < 32'(nm);
  assign c_ok = 32'(coord) < 32'(nd);
  assign last_i = (32'(mi) + 32'd1) == 32'(nm);
  assign last_j = (32'(dj) + 32'd1) == 32'(nd);
  assign sweep_end = ({mi, dj} == '1);
  assign addr_port = {MW'(member), DW'(coord)};
  assign addr_cur = {mi, dj};
  assign addr = (state == pso_pkg::ST_IDLE) ? addr_port : addr_cur;
  assign gb = swarm_pos[dj];
  assign own_imp = !own_marks[mi] || ($signed(cost_r) < $signed(cost_q));

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      pso_pkg::ST_IDLE: begin
        if (acc_in) begin
          priority case (command)
            pso_pkg::CMD_RESTART: state_next = pso_pkg::ST_VCLR;
            pso_pkg::CMD_READ:    if (m_ok && c_ok) state_next = pso_pkg::ST_READ;
            pso_pkg::CMD_REPORT:  if (m_ok) state_next = pso_pkg::ST_RPT;
            pso_pkg::CMD_EVOLVE:  state_next = pso_pkg::ST_EVO;
            default:              state_next = pso_pkg::ST_IDLE;
          endcase
        end
      end
      pso_pkg::ST_READ:    state_next = pso_pkg::ST_IDLE;
      pso_pkg::ST_RPT:     state_next = own_imp ? pso_pkg::ST_COPY_RD : pso_pkg::ST_IDLE;
      pso_pkg::ST_COPY_RD: state_next = pso_pkg::ST_COPY_WR;
      pso_pkg::ST_COPY_WR: state_next = last_j ? pso_pkg::ST_IDLE : pso_pkg::ST_COPY_RD;
      pso_pkg::ST_EVO: begin
        if (ph == 3'd5 && last_i && last_j) state_next = pso_pkg::ST_IDLE;
      end
      pso_pkg::ST_VCLR:    if (sweep_end) state_next = pso_pkg::ST_IDLE;
      default:             state_next = pso_pkg::ST_IDLE;
    endcase
  end

  // Memory strobes and multiplier control.
  always_comb begin
    logic is_load;
    is_load = (state == pso_pkg::ST_IDLE) && acc_in && (command == pso_pkg::CMD_LOAD)
              && m_ok && c_ok;
    rd_en = ((state == pso_pkg::ST_IDLE) && acc_in) || (state == pso_pkg::ST_COPY_RD)
            || ((state == pso_pkg::ST_EVO) && ph == 3'd0);
    pos_we = is_load || ((state == pso_pkg::ST_EVO) && ph == 3'd5);
    pos_wd = (state == pso_pkg::ST_IDLE) ? VB'(load_value) : x_new;
    vel_we = is_load || ((state == pso_pkg::ST_EVO) && ph == 3'd5)
             || (state == pso_pkg::ST_VCLR);
    vel_wd = (state == pso_pkg::ST_EVO) ? v_new : '0;
    pb_we = is_load || (state == pso_pkg::ST_COPY_WR);
    pb_wd = (state == pso_pkg::ST_IDLE) ? VB'(load_value) : pos_q;
    cost_we = (state == pso_pkg::ST_RPT) && own_imp;
    cost_addr = (state == pso_pkg::ST_IDLE) ? MW'(member) : mi;
    mac_ctl = '{mul_en: 1'b0, sel: pso_pkg::SEL_INERTIA, acc_clr: 1'b0, acc_add: 1'b0};
    if (state == pso_pkg::ST_EVO) begin
      unique case (ph)
        3'd1: mac_ctl = '{mul_en: 1'b1, sel: pso_pkg::SEL_INERTIA, acc_clr: 1'b1,
                          acc_add: 1'b0};
        3'd2: mac_ctl = '{mul_en: 1'b1, sel: pso_pkg::SEL_OWN, acc_clr: 1'b0,
                          acc_add: 1'b1};
        3'd3: mac_ctl = '{mul_en: 1'b1, sel: pso_pkg::SEL_SWARM, acc_clr: 1'b0,
                          acc_add: 1'b1};
        3'd4: mac_ctl = '{mul_en: 1'b0, sel: pso_pkg::SEL_INERTIA, acc_clr: 1'b0,
                          acc_add: 1'b1};
        default: mac_ctl = '{mul_en: 1'b0, sel: pso_pkg::SEL_INERTIA, acc_clr: 1'b0,
                             acc_add: 1'b0};
      endcase
    end
  end

  // Control registers, swarm bests and the result word.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pso_pkg::ST_IDLE;
      done <= 1'b0;
      own_marks <= '0;
      swarm_mark <= 1'b0;
      swarm_cost <= pso_pkg::COST_MAX;
      pimp <= 1'b0;
      gimp <= 1'b0;
      ph <= '0;
      inertia_weight <= pso_pkg::INERTIA_RST;
      own_best_gain <= pso_pkg::OWN_GAIN_RST;
      swarm_best_gain <= pso_pkg::SWARM_GAIN_RST;
      members_in_use <= pso_pkg::MEMBERS_RST;
      dims_in_use <= pso_pkg::DIMS_RST;
    end else begin
      state <= state_next;
      done <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          pso_pkg::REG_INERTIA:    inertia_weight <= cfg_data;
          pso_pkg::REG_OWN_GAIN:   own_best_gain <= cfg_data;
          pso_pkg::REG_SWARM_GAIN: swarm_best_gain <= cfg_data;
          pso_pkg::REG_MEMBERS:    members_in_use <= cfg_data[pso_pkg::NMEM_W-1:0];
          pso_pkg::REG_DIMS:       dims_in_use <= cfg_data[pso_pkg::NDIM_W-1:0];
          default: ;
        endcase
      end
      unique case (state)
        pso_pkg::ST_IDLE: begin
          if (acc_in) begin
            mi <= MW'(member);
            dj <= '0;
            ph <= '0;
            cost_r <= cost;
            pimp <= 1'b0;
            gimp <= 1'b0;
            rv <= '0;
            priority case (command)
              pso_pkg::CMD_RESTART: begin
                own_marks <= '0;
                swarm_mark <= 1'b0;
                swarm_cost <= pso_pkg::COST_MAX;
                mi <= '0;
              end
              pso_pkg::CMD_READ:   if (!(m_ok && c_ok)) done <= 1'b1;
              pso_pkg::CMD_REPORT: if (!m_ok) done <= 1'b1;
              pso_pkg::CMD_EVOLVE: mi <= '0;
              pso_pkg::CMD_BEST: begin
                if (c_ok) rv <= pso_pkg::WORD_W'(swarm_pos[DW'(coord)]);
                done <= 1'b1;
              end
              default: done <= 1'b1;
            endcase
          end
        end
        pso_pkg::ST_READ: begin
          rv <= pso_pkg::WORD_W'(pos_q);
          done <= 1'b1;
        end
        pso_pkg::ST_RPT: begin
          if (own_imp) begin
            pimp <= 1'b1;
            own_marks[mi] <= 1'b1;
            if (!swarm_mark || ($signed(cost_r) < $signed(swarm_cost))) begin
              gimp <= 1'b1;
              swarm_mark <= 1'b1;
              swarm_cost <= cost_r;
            end
          end else begin
            done <= 1'b1;
          end
        end
        pso_pkg::ST_COPY_RD: ;
        pso_pkg::ST_COPY_WR: begin
          if (gimp) swarm_pos[dj] <= pos_q;
          if (last_j) done <= 1'b1;
          else dj <= dj + 1'b1;
        end
        pso_pkg::ST_EVO: begin
          if (ph == 3'd5) begin
            ph <= '0;
            if (last_j) begin
              dj <= '0;
              if (last_i) done <= 1'b1;
              else mi <= mi + 1'b1;
            end else begin
              dj <= dj + 1'b1;
            end
          end else begin
            ph <= ph + 3'd1;
          end
        end
        pso_pkg::ST_VCLR: begin
          {mi, dj} <= {mi, dj} + 1'b1;
          if (sweep_end) done <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  pso_ram #(.AW(AW), .W(VB)) u_pos (
    .clk(clk), .we(pos_we), .waddr(addr), .wdata(pos_wd),
    .re(rd_en), .raddr(addr), .rdata(pos_q)
  );

  pso_ram #(.AW(AW), .W(VB)) u_vel (
    .clk(clk), .we(vel_we), .waddr(addr), .wdata(vel_wd),
    .re(rd_en), .raddr(addr), .rdata(vel_q)
  );

  pso_ram #(.AW(AW), .W(VB)) u_pbest (
    .clk(clk), .we(pb_we), .waddr(addr), .wdata(pb_wd),
    .re(rd_en), .raddr(addr), .rdata(pb_q)
  );

  pso_ram #(.AW(MW), .W(pso_pkg::WORD_W)) u_cost (
    .clk(clk), .we(cost_we), .waddr(cost_addr), .wdata(cost_r),
    .re(acc_in), .raddr(cost_addr), .rdata(cost_q)
  );

  pso_mac u_mac (
    .clk(clk), .ctl(mac_ctl),
    .w(inertia_weight), .c1(own_best_gain), .c2(swarm_best_gain),
    .x(pos_q), .v(vel_q), .pb(pb_q), .gb(gb),
    .v_new(v_new), .x_new(x_new)
  );

endmodule

// ===== tb/tb_particle_swarm_update_engine.sv =====
module tb_particle_swarm_update_engine;
  import pso_pkg::*;

  localparam int NPOP = 32;
  localparam int NDIM = 8;
  localparam longint WMAX = 64'sd2147483647;
  localparam longint WMIN = -64'sd2147483648;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  logic [CMD_W-1:0] command;
  logic [MEMBER_W-1:0] member;
  logic [COORD_W-1:0] coord;
  logic signed [WORD_W-1:0] load_value;
  logic signed [WORD_W-1:0] cost;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic done;
  logic signed [WORD_W-1:0] read_value;
  logic signed [WORD_W-1:0] best_cost;
  logic best_valid;
  logic particle_improved;
  logic global_improved;

  particle_swarm_update_engine u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .command(command), .member(member), .coord(coord),
    .load_value(load_value), .cost(cost),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .done(done), .read_value(read_value), .best_cost(best_cost),
    .best_valid(best_valid), .particle_improved(particle_improved),
    .global_improved(global_improved)
  );

  // One planned word: either a register write or a command.
  typedef struct {
    bit is_cfg;
    int idle_pct;
    logic [CMD_W-1:0] cmd;
    logic [MEMBER_W-1:0] mem;
    logic [COORD_W-1:0] crd;
    logic [WORD_W-1:0] lv;
    logic [WORD_W-1:0] cst;
    logic [CFG_IDX_W-1:0] ridx;
    logic [CFG_DATA_W-1:0] rdata;
  } plan_t;

  typedef struct {
    logic [WORD_W-1:0] rv;
    logic [WORD_W-1:0] bc;
    logic bv;
    logic pi;
    logic gi;
  } swarm_result_t;

  plan_t work_plan[$];
  swarm_result_t pending_results[$];
  int errors = 0;
  int quiet = 0;
  plan_t cur;

  // Predicted engine state.
  longint pos[NPOP*NDIM];
  longint vel[NPOP*NDIM];
  longint pbest[NPOP*NDIM];
  longint pbest_cost[NPOP];
  bit pbest_mark[NPOP];
  longint gbest[NDIM];
  longint gbest_cost;
  bit gbest_mark;
  logic [15:0] w_reg, c1_reg, c2_reg;
  logic [5:0] nm_reg;
  logic [3:0] nd_reg;

  // Planning-side view of which entries hold defined values.
  bit pos_known[NPOP*NDIM];
  bit gbest_known[NDIM];
  bit reported_since_restart;
  int plan_nm, plan_nd;

  function automatic longint clip(longint v);
    return v > WMAX ? WMAX : (v < WMIN ? WMIN : v);
  endfunction

  function automatic int clamp_range(int v, int hi);
    return v < 1 ? 1 : (v > hi ? hi : v);
  endfunction

  task automatic clear_swarm();
    for (int k = 0; k < NPOP*NDIM; k++) vel[k] = 0;
    for (int i = 0; i < NPOP; i++) pbest_mark[i] = 0;
    gbest_cost = WMAX;
    gbest_mark = 0;
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    case (idx)
      REG_INERTIA: w_reg = d;
      REG_OWN_GAIN: c1_reg = d;
      REG_SWARM_GAIN: c2_reg = d;
      REG_MEMBERS: nm_reg = d[5:0];
      REG_DIMS: nd_reg = d[3:0];
      default: ;
    endcase
  endtask

  // Work out the result of one accepted command and update the state.
  task automatic predict_swarm_step(plan_t it);
    int nm, nd, m, c, k;
    bit m_ok, c_ok;
    longint rv, x, s, v, cv;
    swarm_result_t r;
    nm = clamp_range(int'(nm_reg), NPOP);
    nd = clamp_range(int'(nd_reg), NDIM);
    m = int'(it.mem);
    c = int'(it.crd);
    m_ok = m < nm;
    c_ok = c < nd;
    rv = 0;
    r.pi = 0;
    r.gi = 0;
    case (it.cmd)
      CMD_RESTART: clear_swarm();
      CMD_LOAD: if (m_ok && c_ok) begin
        pos[m*NDIM+c] = longint'($signed(it.lv));
        pbest[m*NDIM+c] = longint'($signed(it.lv));
        vel[m*NDIM+c] = 0;
      end
      CMD_READ: if (m_ok && c_ok) rv = pos[m*NDIM+c];
      CMD_REPORT: if (m_ok) begin
        cv = longint'($signed(it.cst));
        if (!pbest_mark[m] || cv < pbest_cost[m]) begin
          r.pi = 1;
          pbest_mark[m] = 1;
          pbest_cost[m] = cv;
          for (int j = 0; j < nd; j++) pbest[m*NDIM+j] = pos[m*NDIM+j];
          if (!gbest_mark || cv < gbest_cost) begin
            r.gi = 1;
            gbest_mark = 1;
            gbest_cost = cv;
            for (int j = 0; j < nd; j++) gbest[j] = pos[m*NDIM+j];
          end
        end
      end
      CMD_EVOLVE: for (int i = 0; i < nm; i++) begin
        for (int j = 0; j < nd; j++) begin
          k = i*NDIM + j;
          x = pos[k];
          s = 2 * longint'(w_reg) * vel[k] + longint'(c1_reg) * (pbest[k] - x)
              + longint'(c2_reg) * (gbest[j] - x);
          v = clip(s >>> 13);
          vel[k] = v;
          pos[k] = clip(x + v);
        end
      end
      CMD_BEST: if (c_ok) rv = gbest[c];
      default: ;
    endcase
    r.rv = rv[31:0];
    r.bc = gbest_cost[31:0];
    r.bv = gbest_mark;
    pending_results.insert(pending_results.size(), r);
  endtask

  // Planning helpers.
  task automatic plan_cfg(logic [CFG_IDX_W-1:0] idx, int d);
    plan_t p;
    p = '{default: '0};
    p.is_cfg = 1;
    p.ridx = idx;
    p.rdata = d[15:0];
    if (idx == REG_MEMBERS) plan_nm = clamp_range(d & 63, NPOP);
    if (idx == REG_DIMS) plan_nd = clamp_range(d & 15, NDIM);
    work_plan.insert(work_plan.size(), p);
  endtask

  task automatic plan_cmd(int idle, logic [CMD_W-1:0] cmd, int m, int c,
                          logic [31:0] lv, logic [31:0] cst);
    plan_t p;
    p = '{default: '0};
    p.idle_pct = idle;
    p.cmd = cmd;
    p.mem = m[4:0];
    p.crd = c[2:0];
    p.lv = lv;
    p.cst = cst;
    if (cmd == CMD_LOAD && m < plan_nm && c < plan_nd) pos_known[m*NDIM+c] = 1;
    if (cmd == CMD_RESTART) reported_since_restart = 0;
    if (cmd == CMD_REPORT && m < plan_nm && !reported_since_restart) begin
      // The first report after a restart always sets the global best row.
      reported_since_restart = 1;
      for (int j = 0; j < plan_nd; j++) gbest_known[j] = 1;
    end
    work_plan.insert(work_plan.size(), p);
  endtask

  function automatic bit row_known(int m);
    for (int j = 0; j < plan_nd; j++) if (!pos_known[m*NDIM+j]) return 0;
    return 1;
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0;
      3: return 32'(int'($urandom_range(4000)) - 2000) <<< 16;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_cost();
    case ($urandom_range(9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom;
      default: return 32'(int'($urandom_range(2000)) - 1000);
    endcase
  endfunction

  // Random command that never touches an entry that was never written.
  task automatic plan_random(int idle);
    int sel, m, c, fill_m, fill_c;
    bit ok, found;
    logic [CMD_W-1:0] cmd;
    sel = $urandom_range(99);
    m = ($urandom_range(9) < 8) ? $urandom_range(plan_nm - 1) : $urandom_range(31);
    c = ($urandom_range(9) < 8) ? $urandom_range(plan_nd - 1) : $urandom_range(7);
    if (sel < 30) cmd = CMD_LOAD;
    else if (sel < 48) cmd = CMD_READ;
    else if (sel < 73) cmd = CMD_REPORT;
    else if (sel < 80) cmd = CMD_EVOLVE;
    else if (sel < 91) cmd = CMD_BEST;
    else if (sel < 94) cmd = CMD_RESTART;
    else cmd = CMD_W'($urandom_range(6, 7));
    found = 0;
    fill_m = 0;
    fill_c = 0;
    for (int i = 0; i < plan_nm && !found; i++) begin
      for (int j = 0; j < plan_nd && !found; j++) begin
        if (!pos_known[i*NDIM+j]) begin
          found = 1;
          fill_m = i;
          fill_c = j;
        end
      end
    end
    case (cmd)
      CMD_READ: ok = !(m < plan_nm && c < plan_nd) || pos_known[m*NDIM+c];
      CMD_REPORT: ok = m >= plan_nm || row_known(m);
      CMD_BEST: ok = c >= plan_nd || gbest_known[c];
      CMD_EVOLVE: begin
        ok = !found;
        for (int j = 0; j < plan_nd; j++) if (!gbest_known[j]) ok = 0;
      end
      default: ok = 1;
    endcase
    if (ok) plan_cmd(idle, cmd, m, c, pick_value(), pick_cost());
    else if (found) plan_cmd(idle, CMD_LOAD, fill_m, fill_c, pick_value(), 0);
    else plan_cmd(idle, CMD_REPORT, 0, 0, 0, pick_cost());
  endtask

  task automatic plan_phase(int w, int c1, int c2, int nm, int nd, int idle, int count);
    plan_cfg(REG_INERTIA, w);
    plan_cfg(REG_OWN_GAIN, c1);
    plan_cfg(REG_SWARM_GAIN, c2);
    plan_cfg(REG_MEMBERS, nm);
    plan_cfg(REG_DIMS, nd);
    for (int i = 0; i < count; i++) plan_random(idle);
  endtask

  // Clock.
  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Driver: commands and register writes from the plan.
  always @(posedge clk) begin
    bit took, go, wr, new_cmd, new_cfg;
    plan_t it;
    if (rst) begin
      start <= 0;
      cfg_valid <= 0;
      w_reg = INERTIA_RST;
      c1_reg = OWN_GAIN_RST;
      c2_reg = SWARM_GAIN_RST;
      nm_reg = MEMBERS_RST;
      nd_reg = DIMS_RST;
      clear_swarm();
      quiet = 0;
    end else begin
      took = start && !busy;
      if (took) predict_swarm_step(cur);
      if (cfg_valid && cfg_ready) write_register(cfg_index, cfg_data);
      go = start && !took;
      wr = cfg_valid && !cfg_ready;
      new_cmd = 0;
      new_cfg = 0;
      if (!go && !wr && !cfg_valid && work_plan.size() > 0) begin
        if (work_plan[0].is_cfg) begin
          if (!took && !busy && pending_results.size() == 0 && quiet >= 8) begin
            it = work_plan.pop_front();
            new_cfg = 1;
            cfg_index <= it.ridx;
            cfg_data <= it.rdata;
          end
        end else if ($urandom_range(99) >= work_plan[0].idle_pct) begin
          it = work_plan.pop_front();
          cur = it;
          new_cmd = 1;
          command <= it.cmd;
          member <= it.mem;
          coord <= it.crd;
          load_value <= it.lv;
          cost <= it.cst;
        end
      end
      start <= go || new_cmd;
      cfg_valid <= wr || new_cfg;
      if (go || new_cmd || busy || cfg_valid || pending_results.size() != 0) quiet = 0;
      else quiet = quiet + 1;
    end
  end

  task automatic note_mismatch(string what, logic [31:0] want, logic [31:0] got);
    errors++;
    if (errors <= 10)
      $display("mismatch %s: expected %h, got %h", what, want, got);
  endtask

  // Monitor: every result word against the oldest prediction.
  always @(posedge clk) begin
    swarm_result_t e;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 10) $display("result word with nothing expected");
      end else begin
        e = pending_results.pop_front();
        if (read_value !== e.rv) note_mismatch("read_value", e.rv, read_value);
        if (best_cost !== e.bc) note_mismatch("best_cost", e.bc, best_cost);
        if (best_valid !== e.bv) note_mismatch("best_valid", 32'(e.bv), 32'(best_valid));
        if (particle_improved !== e.pi)
          note_mismatch("particle_improved", 32'(e.pi), 32'(particle_improved));
        if (global_improved !== e.gi)
          note_mismatch("global_improved", 32'(e.gi), 32'(global_improved));
      end
    end
  end

  // Stimulus plan, reset and end of run.
  initial begin
    rst = 1;
    start = 0;
    cfg_valid = 0;
    command = '0;
    member = '0;
    coord = '0;
    load_value = '0;
    cost = '0;
    cfg_index = '0;
    cfg_data = '0;
    plan_nm = NPOP;
    plan_nd = NDIM;
    reported_since_restart = 0;
    for (int k = 0; k < NPOP*NDIM; k++) pos_known[k] = 0;
    for (int j = 0; j < NDIM; j++) gbest_known[j] = 0;

    // Directed part on a two by two swarm with the largest gains.
    plan_cfg(REG_INERTIA, 65535);
    plan_cfg(REG_OWN_GAIN, 65535);
    plan_cfg(REG_SWARM_GAIN, 65535);
    plan_cfg(REG_MEMBERS, 2);
    plan_cfg(REG_DIMS, 2);
    plan_cmd(0, CMD_RESTART, 0, 0, 0, 0);
    plan_cmd(0, CMD_LOAD, 0, 0, 32'h7FFF_FFFF, 0);
    plan_cmd(0, CMD_LOAD, 0, 1, 32'h8000_0000, 0);
    plan_cmd(0, CMD_LOAD, 1, 0, 32'h0, 0);
    plan_cmd(0, CMD_LOAD, 1, 1, 32'hFFFF_FFFF, 0);
    plan_cmd(0, CMD_LOAD, 31, 0, 32'h1234_5678, 0);
    plan_cmd(0, CMD_LOAD, 0, 7, 32'h1234_5678, 0);
    plan_cmd(0, CMD_READ, 0, 0, 0, 0);
    plan_cmd(0, CMD_READ, 1, 1, 0, 0);
    plan_cmd(0, CMD_READ, 31, 0, 0, 0);
    plan_cmd(0, CMD_READ, 0, 7, 0, 0);
    plan_cmd(0, CMD_REPORT, 0, 0, 0, 32'h7FFF_FFFF);
    plan_cmd(0, CMD_REPORT, 0, 0, 0, 32'h8000_0000);
    plan_cmd(0, CMD_REPORT, 0, 0, 0, 32'h8000_0000);
    plan_cmd(0, CMD_REPORT, 1, 0, 0, 32'h5);
    plan_cmd(0, CMD_REPORT, 31, 0, 0, 32'h8000_0000);
    plan_cmd(0, CMD_BEST, 0, 0, 0, 0);
    plan_cmd(0, CMD_BEST, 0, 7, 0, 0);
    plan_cmd(0, CMD_EVOLVE, 0, 0, 0, 0);
    plan_cmd(0, CMD_READ, 0, 0, 0, 0);
    plan_cmd(0, CMD_READ, 1, 1, 0, 0);
    plan_cmd(0, 3'd6, 0, 0, 0, 0);
    plan_cmd(0, 3'd7, 0, 0, 0, 0);
    plan_cmd(0, CMD_RESTART, 0, 0, 0, 0);
    plan_cmd(0, CMD_REPORT, 1, 0, 0, 32'd100);

    // Random phases, register settings including out-of-range sizes.
    plan_phase(0, 0, 0, 0, 0, 0, 150);
    plan_phase(2986, 6121, 6121, 4, 3, 60, 160);
    plan_phase($urandom_range(65535), $urandom_range(65535), $urandom_range(65535),
               63, 15, 17, 140);
    plan_phase(65535, 65535, 65535, 7, 8, 60, 160);
    plan_phase($urandom_range(8191), $urandom_range(8191), $urandom_range(8191),
               32, 1, 0, 160);
    plan_phase(4096, 8192, 8192, 1, 8, 17, 160);

    repeat (10) @(posedge clk);
    rst <= 0;
    wait (work_plan.size() == 0 && !start && !cfg_valid && pending_results.size() == 0);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("** particle_swarm_update_engine: PASSED **");
    end else begin
      $display("** particle_swarm_update_engine: FAILED **");
    end
    $finish;
  end

  // Timeout.
  initial begin
    #100000000;
    $display("** particle_swarm_update_engine: FAILED **");
    $finish;
  end

endmodule
